### hdl/fsw_pkg.sv
// ----------------------------------------------------------------------------
// fsw_pkg: shared types and constants of the devicetree structure walker
// Token codes, event and finish codes, the queue entry and the status groups.
// ----------------------------------------------------------------------------
package fsw_pkg;

   localparam logic [31:0] WalkMagic    = 32'hD00DFEED;
   localparam logic [31:0] TokBeginNode = 32'h00000001;
   localparam logic [31:0] TokEndNode   = 32'h00000002;
   localparam logic [31:0] TokProp      = 32'h00000003;
   localparam logic [31:0] TokNop       = 32'h00000004;
   localparam logic [31:0] TokEnd       = 32'h00000009;

   localparam int QueueDepth = 4;
   localparam int QPtrWidth  = $clog2(QueueDepth);
   localparam int QCntWidth  = $clog2(QueueDepth + 1);

   localparam int CsrAddrWidth = 4;

   typedef enum logic [1:0] {
      REG_MAGIC       = 2'd0,
      REG_STRUCT_OFF  = 2'd1,
      REG_STRINGS_OFF = 2'd2,
      REG_BLOCK_SIZE  = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      EV_BEGIN  = 2'd0,
      EV_END    = 2'd1,
      EV_PROP   = 2'd2,
      EV_FINISH = 2'd3
   } event_kind_type;

   typedef enum logic [1:0] {
      FIN_END     = 2'd0,
      FIN_UNKNOWN = 2'd1,
      FIN_SIZE    = 2'd2,
      FIN_MAGIC   = 2'd3
   } finish_reason_type;

   typedef enum logic [2:0] {
      TC_BEGIN_NODE = 3'd0,
      TC_END_NODE   = 3'd1,
      TC_PROP       = 3'd2,
      TC_NOP        = 3'd3,
      TC_END        = 3'd4,
      TC_OTHER      = 3'd5
   } token_class_type;

   typedef enum logic [6:0] {
      PH_FIRST   = 7'b0000001,
      PH_TOKEN   = 7'b0000010,
      PH_NAME    = 7'b0000100,
      PH_LEN     = 7'b0001000,
      PH_NAMEOFF = 7'b0010000,
      PH_PAYLOAD = 7'b0100000,
      PH_DONE    = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [31:0]     word;
      token_class_type tok;
      logic            has_zero;
   } entry_type;

   typedef struct packed {
      logic [31:0] header_magic;
      logic [31:0] struct_offset;
      logic [31:0] strings_offset;
      logic [31:0] block_size;
   } cfg_type;

   typedef struct packed {
      logic walk_done;
      logic take;
   } back_status_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } queue_status_type;

endpackage

### hdl/fsw_if.sv
// ----------------------------------------------------------------------------
// fsw_if: channel interfaces of the devicetree structure walker
// Word channel into the walker and event channel out of it.
// ----------------------------------------------------------------------------
interface fsw_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface fsw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] name_address;
   logic [31:0] value_address;
   logic [31:0] value_length;
   logic [1:0]  finish_reason;

   modport source (output valid, output event_kind, output name_address,
                   output value_address, output value_length,
                   output finish_reason, input ready);
   modport sink   (input valid, input event_kind, input name_address,
                   input value_address, input value_length,
                   input finish_reason, output ready);
endinterface

### hdl/fsw_queue.sv
// ----------------------------------------------------------------------------
// fsw_queue: short word queue between the classifier and the parser
// Register-based FIFO of classified words; the head is visible without a pop.
// ----------------------------------------------------------------------------
module fsw_queue
   import fsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_data,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   entry_type              mem_ff [QueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0]   count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full       = (count_ff == QCntWidth'(QueueDepth));
   assign status.head_valid = (count_ff != '0);
   assign head              = mem_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hdl/fsw_front.sv
// ----------------------------------------------------------------------------
// fsw_front: word intake and token classification
// Accepts structure words, decodes the token value and the zero-byte flag,
// and writes the classified word into the queue.
// ----------------------------------------------------------------------------
module fsw_front
   import fsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   fsw_req_if.sink          req_ch,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type q_status
);

   entry_type classified;

   always_comb begin
      classified.word     = req_ch.word;
      classified.has_zero = (req_ch.word[31:24] == 8'h00) || (req_ch.word[23:16] == 8'h00) ||
                            (req_ch.word[15:8] == 8'h00)  || (req_ch.word[7:0] == 8'h00);
      case (req_ch.word)
         TokBeginNode: classified.tok = TC_BEGIN_NODE;
         TokEndNode:   classified.tok = TC_END_NODE;
         TokProp:      classified.tok = TC_PROP;
         TokNop:       classified.tok = TC_NOP;
         TokEnd:       classified.tok = TC_END;
         default:      classified.tok = TC_OTHER;
      endcase
   end

   assign req_ch.ready = !q_status.full;

   fsw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_ch.valid),
      .push_data (classified),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

endmodule

### hdl/fsw_back.sv
// ----------------------------------------------------------------------------
// fsw_back: structure block parser and event output register
// Walks the token grammar one queued word per cycle unless the event output stalls,
// and registers the resulting begin-node, end-node, property and finish events.
// ----------------------------------------------------------------------------
module fsw_back
   import fsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  entry_type        head,
   input  queue_status_type q_status,
   output back_status_type  status,
   fsw_rsp_if.source        rsp_ch
);

   phase_type         phase_ff, phase_in;
   logic [31:0]       pos_ff, pos_in;
   logic [29:0]       left_ff, left_in;
   logic [31:0]       held_ff, held_in;

   logic              out_valid_ff, out_valid_in;
   event_kind_type    kind_ff, kind_in;
   logic [31:0]       name_ff, name_in;
   logic [31:0]       value_ff, value_in;
   logic [31:0]       length_ff, length_in;
   finish_reason_type reason_ff, reason_in;

   logic              take;
   logic              emit;
   logic [31:0]       next_pos;

   assign take     = q_status.head_valid && (!out_valid_ff || rsp_ch.ready);
   assign next_pos = pos_ff + 32'd4;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      held_in   = held_ff;
      emit      = 1'b0;
      kind_in   = EV_FINISH;
      name_in   = '0;
      value_in  = '0;
      length_in = '0;
      reason_in = FIN_END;
      if (take) begin
         case (phase_ff)
            PH_FIRST, PH_TOKEN: begin
               if ((phase_ff == PH_FIRST) && (cfg.header_magic != WalkMagic)) begin
                  phase_in  = PH_DONE;
                  emit      = 1'b1;
                  reason_in = FIN_MAGIC;
               end else if (pos_ff >= cfg.block_size) begin
                  phase_in  = PH_DONE;
                  emit      = 1'b1;
                  reason_in = FIN_SIZE;
               end else begin
                  pos_in   = next_pos;
                  phase_in = PH_TOKEN;
                  case (head.tok)
                     TC_BEGIN_NODE: begin
                        phase_in = PH_NAME;
                        emit     = 1'b1;
                        kind_in  = EV_BEGIN;
                        name_in  = cfg.struct_offset + next_pos;
                     end
                     TC_END_NODE: begin
                        emit    = 1'b1;
                        kind_in = EV_END;
                     end
                     TC_PROP: begin
                        phase_in = PH_LEN;
                     end
                     TC_NOP: begin
                        phase_in = PH_TOKEN;
                     end
                     TC_END: begin
                        phase_in  = PH_DONE;
                        emit      = 1'b1;
                        reason_in = FIN_END;
                     end
                     default: begin
                        phase_in  = PH_DONE;
                        emit      = 1'b1;
                        reason_in = FIN_UNKNOWN;
                     end
                  endcase
               end
            end
            PH_NAME: begin
               pos_in = next_pos;
               if (head.has_zero) begin
                  phase_in = PH_TOKEN;
               end
            end
            PH_LEN: begin
               pos_in   = next_pos;
               held_in  = head.word;
               phase_in = PH_NAMEOFF;
            end
            PH_NAMEOFF: begin
               pos_in    = next_pos;
               emit      = 1'b1;
               kind_in   = EV_PROP;
               name_in   = cfg.strings_offset + head.word;
               value_in  = cfg.struct_offset + next_pos;
               length_in = held_ff;
               // The payload spans the length rounded up to whole words; the
               // current count excludes the first payload word.
               if (held_ff == '0) begin
                  phase_in = PH_TOKEN;
               end else begin
                  phase_in = PH_PAYLOAD;
                  left_in  = (held_ff[1:0] != 2'b00) ? held_ff[31:2]
                                                     : held_ff[31:2] - 30'd1;
               end
            end
            PH_PAYLOAD: begin
               pos_in = next_pos;
               if (left_ff == '0) begin
                  phase_in = PH_TOKEN;
               end else begin
                  left_in = left_ff - 30'd1;
               end
            end
            default: begin
               // Walk finished: words are drained and ignored.
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      if (take) begin
         out_valid_in = emit;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         pos_ff       <= '0;
         left_ff      <= '0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         kind_ff   <= kind_in;
         name_ff   <= name_in;
         value_ff  <= value_in;
         length_ff <= length_in;
         reason_ff <= reason_in;
      end
   end

   assign status.walk_done = (phase_ff == PH_DONE);
   assign status.take      = take;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.event_kind    = kind_ff;
   assign rsp_ch.name_address  = name_ff;
   assign rsp_ch.value_address = value_ff;
   assign rsp_ch.value_length  = length_ff;
   assign rsp_ch.finish_reason = reason_ff;

endmodule

### hdl/fdt_structure_walker_core.sv
// Path: a word enters the queue, then the parser registers its event.
// Throughput: one word per cycle at best; the parser takes one queued word
// per cycle whenever the event register is empty or being drained.
// A four-entry queue separates word intake from the parser.
// Reset is synchronous and active high; control and configuration registers return
// to their defaults at once, with no clearing pass.
// ----------------------------------------------------------------------------
// fdt_structure_walker_core: flattened devicetree structure block walker
// Classifies structure words, tracks node names and property payloads, and
// reports node, property and finish events; configured over an APB port.
// ----------------------------------------------------------------------------
module fdt_structure_walker_core
   import fsw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   fsw_req_if.sink                 req_ch,
   fsw_rsp_if.source               rsp_ch,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CsrAddrWidth-1:0] csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   cfg_type          cfg_ff, cfg_in;
   entry_type        head;
   queue_status_type q_status;
   back_status_type  b_status;
   reg_index_type    reg_sel;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (reg_sel)
            REG_MAGIC:       cfg_in.header_magic   = csr_pwdata;
            REG_STRUCT_OFF:  cfg_in.struct_offset  = csr_pwdata;
            REG_STRINGS_OFF: cfg_in.strings_offset = csr_pwdata;
            REG_BLOCK_SIZE:  cfg_in.block_size     = csr_pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAGIC:       csr_prdata = cfg_ff.header_magic;
         REG_STRUCT_OFF:  csr_prdata = cfg_ff.struct_offset;
         REG_STRINGS_OFF: csr_prdata = cfg_ff.strings_offset;
         REG_BLOCK_SIZE:  csr_prdata = cfg_ff.block_size;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_magic   <= WalkMagic;
         cfg_ff.struct_offset  <= '0;
         cfg_ff.strings_offset <= '0;
         cfg_ff.block_size     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fsw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .pop      (b_status.take),
      .head     (head),
      .q_status (q_status)
   );

   fsw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_status (q_status),
      .status   (b_status),
      .rsp_ch   (rsp_ch)
   );

`ifndef SYNTHESIS
   // Once the walk has finished it stays finished until reset.
   assert property (@(posedge clock) disable iff (reset)
      b_status.walk_done |=> b_status.walk_done)
      else $error("walk left the finished state without reset");

   // No event may follow a delivered finish event.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && (rsp_ch.event_kind == EV_FINISH))
      |=> !rsp_ch.valid)
      else $error("event issued after finish");

   // Only finish events carry a non-zero reason.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.event_kind != EV_FINISH)) |-> (rsp_ch.finish_reason == FIN_END))
      else $error("non-finish event with a finish reason");
`endif

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the devicetree structure walker
// Feeds one long, well-formed walk made of nodes, properties and NOPs with
// random contents. The offsets and the size are reprogrammed between phases.
// The walk ends in one of several ways: end token, unknown token, size
// reached, or a property so long that its payload is never left. Every
// event is checked against a cycle-free prediction of the walk.
// ----------------------------------------------------------------------------
module testbench;
   import fsw_pkg::*;

   typedef struct packed {
      event_kind_type    kind;
      logic [31:0]       name_addr;
      logic [31:0]       value_addr;
      logic [31:0]       value_len;
      finish_reason_type reason;
   } walk_event_type;

   logic                    clock;
   logic                    reset;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   fsw_req_if req_bus();
   fsw_rsp_if rsp_bus();

   fdt_structure_walker_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Words waiting to be sent and events still owed by the walker.
   logic [31:0] word_queue[$];
   walk_event_type expected_events[$];
   int          words_queued = 0;
   int          words_taken  = 0;
   int          error_count  = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   // Predicted walker state and its copy of the registers.
   logic [31:0] cfg_magic;
   logic [31:0] cfg_struct_off;
   logic [31:0] cfg_strings_off;
   logic [31:0] cfg_block_size;
   phase_type   walk_phase;
   logic [31:0] byte_pos;
   logic [29:0] payload_left;
   logic [31:0] held_len;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void push_event(input event_kind_type kind, input logic [31:0] name_addr,
                                      input logic [31:0] value_addr,
                                      input logic [31:0] value_len,
                                      input finish_reason_type reason);
      walk_event_type ev;
      ev.kind       = kind;
      ev.name_addr  = name_addr;
      ev.value_addr = value_addr;
      ev.value_len  = value_len;
      ev.reason     = reason;
      expected_events.push_back(ev);
      if (kind == EV_FINISH)
         walk_phase = PH_DONE;
   endfunction

   // Advances the predicted walk by one accepted word.
   function automatic void walk_word(input logic [31:0] w);
      logic [31:0] pos_next;
      logic [31:0] words;
      pos_next = byte_pos + 32'd4;
      case (walk_phase)
         PH_FIRST, PH_TOKEN: begin
            if (walk_phase == PH_FIRST && cfg_magic != WalkMagic) begin
               push_event(EV_FINISH, '0, '0, '0, FIN_MAGIC);
            end else if (byte_pos >= cfg_block_size) begin
               push_event(EV_FINISH, '0, '0, '0, FIN_SIZE);
            end else begin
               byte_pos   = pos_next;
               walk_phase = PH_TOKEN;
               case (w)
                  TokBeginNode: begin
                     walk_phase = PH_NAME;
                     push_event(EV_BEGIN, cfg_struct_off + pos_next, '0, '0, FIN_END);
                  end
                  TokEndNode: push_event(EV_END, '0, '0, '0, FIN_END);
                  TokProp:    walk_phase = PH_LEN;
                  TokNop:     ;
                  TokEnd:     push_event(EV_FINISH, '0, '0, '0, FIN_END);
                  default:    push_event(EV_FINISH, '0, '0, '0, FIN_UNKNOWN);
               endcase
            end
         end
         PH_NAME: begin
            byte_pos = pos_next;
            if (w[31:24] == 8'h00 || w[23:16] == 8'h00 || w[15:8] == 8'h00 || w[7:0] == 8'h00)
               walk_phase = PH_TOKEN;
         end
         PH_LEN: begin
            byte_pos   = pos_next;
            held_len   = w;
            walk_phase = PH_NAMEOFF;
         end
         PH_NAMEOFF: begin
            // Padded payload size in words; cannot overflow 32 bits.
            words    = {2'b00, held_len[31:2]} + {31'd0, held_len[1:0] != 2'b00};
            byte_pos = pos_next;
            if (words == 32'd0) begin
               walk_phase = PH_TOKEN;
            end else begin
               payload_left = 30'(words - 32'd1);
               walk_phase   = PH_PAYLOAD;
            end
            push_event(EV_PROP, cfg_strings_off + w, cfg_struct_off + pos_next, held_len,
                       FIN_END);
         end
         PH_PAYLOAD: begin
            byte_pos = pos_next;
            if (payload_left == 30'd0)
               walk_phase = PH_TOKEN;
            else
               payload_left = payload_left - 30'd1;
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%08h, got 0x%08h", field, want, got);
         error_count++;
      end
   endfunction

   // Word driver: one transaction per handshake, sender gaps at random.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.word  <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            walk_word(req_bus.word);
            words_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.word  <= word_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Event monitor: random back-pressure, in-order compare.
   always @(posedge clock) begin
      walk_event_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_events.size() == 0) begin
               $error("unexpected event: kind %0d name 0x%08h", rsp_bus.event_kind,
                      rsp_bus.name_address);
               error_count++;
            end else begin
               want = expected_events.pop_front();
               compare_field("event_kind", 32'(want.kind), 32'(rsp_bus.event_kind));
               compare_field("name_address", want.name_addr, rsp_bus.name_address);
               compare_field("value_address", want.value_addr, rsp_bus.value_address);
               compare_field("value_length", want.value_len, rsp_bus.value_length);
               compare_field("finish_reason", 32'(want.reason), 32'(rsp_bus.finish_reason));
            end
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic queue_word(input logic [31:0] w);
      word_queue.push_back(w);
      words_queued++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_MAGIC:       cfg_magic       = value;
         REG_STRUCT_OFF:  cfg_struct_off  = value;
         REG_STRINGS_OFF: cfg_strings_off = value;
         REG_BLOCK_SIZE:  cfg_block_size  = value;
         default: ;
      endcase
   endtask

   // Waits for every word to be taken and every event to arrive, then lets
   // words that cause no event work their way out of the walker's queue.
   task automatic settle_walker();
      while (words_taken != words_queued || expected_events.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic add_node(input int name_words);
      logic [31:0] w;
      queue_word(TokBeginNode);
      for (int i = 0; i < name_words; i++) begin
         if (i == name_words - 1) begin
            w = $urandom;
            w[8 * $urandom_range(0, 3) +: 8] = 8'h00;
         end else begin
            w = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
         end
         queue_word(w);
      end
   endtask

   task automatic add_property(input logic [31:0] len, input logic [31:0] name_off,
                               input int body_words);
      queue_word(TokProp);
      queue_word(len);
      queue_word(name_off);
      repeat (body_words) queue_word($urandom);
   endtask

   initial begin
      int          len;
      int          pick;
      int          ending;
      int          phase_start;

      reset       = 1'b1;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      req_bus.valid = 1'b0;
      req_bus.word  = '0;
      rsp_bus.ready = 1'b0;

      cfg_magic       = WalkMagic;
      cfg_struct_off  = '0;
      cfg_strings_off = '0;
      cfg_block_size  = '0;
      walk_phase      = PH_FIRST;
      byte_pos        = '0;
      payload_left    = '0;
      held_len        = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      recv_idle_pct = 81;
      csr_write(REG_MAGIC, WalkMagic);
      csr_write(REG_STRUCT_OFF, 32'h0);
      csr_write(REG_STRINGS_OFF, 32'h0);
      csr_write(REG_BLOCK_SIZE, 32'hFFFF_FFFF);

      // Directed walk: an empty name, a terminator in an inner byte lane, zero and
      // odd lengths, extreme name offsets.
      queue_word(TokNop);
      queue_word(TokBeginNode);
      queue_word(32'h0000_0000);
      queue_word(TokBeginNode);
      queue_word(32'h0102_0304);
      queue_word(32'hFFFF_FFFF);
      queue_word(32'hFF00_FFFF);
      add_property(32'd0, 32'hFFFF_FFFF, 0);
      add_property(32'd1, 32'h0000_0000, 1);
      add_property(32'd4, 32'h8000_0000, 1);
      add_property(32'd5, $urandom, 2);
      queue_word(TokEndNode);
      queue_word(TokEndNode);
      settle_walker();

      for (int p = 0; p < 6; p++) begin
         send_idle_pct = (p < 2) ? 25 : (p < 4) ? 81 : 0;
         recv_idle_pct = (p < 2) ? 81 : (p < 4) ? 25 : 0;
         // The magic word is only checked on the first word, so a bad value
         // written mid-walk must change nothing.
         csr_write(REG_MAGIC, (p % 2 == 1) ? 32'h0 : 32'hFFFF_FFFF);
         csr_write(REG_STRUCT_OFF,
                   (p % 3 == 0) ? 32'hFFFF_FFFF : (p % 3 == 1) ? $urandom : 32'h0);
         csr_write(REG_STRINGS_OFF,
                   (p % 3 == 2) ? 32'hFFFF_FFFF : (p % 3 == 0) ? $urandom : 32'h0);
         csr_write(REG_BLOCK_SIZE, (p % 2 == 0) ? 32'h0001_0000 : 32'hFFFF_FFFF);
         phase_start = words_queued;
         while (words_queued - phase_start < 68) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               add_node($urandom_range(1, 4));
            end else if (pick < 5) begin
               queue_word(TokEndNode);
            end else if (pick < 9) begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(0, 16);
               add_property(len, $urandom, (len + 3) / 4);
            end else begin
               queue_word(TokNop);
            end
         end
         settle_walker();
      end

      ending = $urandom_range(0, 3);
      case (ending)
         0: queue_word(TokEnd);
         1: queue_word(($urandom_range(0, 1) == 0) ? 32'h0000_0005 : ($urandom | 32'h8000_0000));
         2: begin
            // A few tokens may still fit before the size limit bites.
            csr_write(REG_BLOCK_SIZE,
                      ($urandom_range(0, 1) == 0) ? 32'h0 : byte_pos + 4 * $urandom_range(0, 3));
            repeat (6) queue_word(TokNop);
         end
         default: add_property($urandom | 32'hC000_0000, $urandom, 3);
      endcase
      // Trailing words must be ignored, or skipped as payload.
      queue_word(TokBeginNode);
      queue_word(TokEndNode);
      repeat (6) queue_word($urandom);
      settle_walker();

      if (expected_events.size() != 0) begin
         $error("%0d expected events never arrived", expected_events.size());
         error_count++;
      end
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
